// ===== design/assert_macros.svh =====
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/plcile_pkg.sv =====
// Package: instruction codes, opcodes and sequencer states of the executor
`default_nettype none
package plcile_pkg;
  localparam logic [1:0] OPC_EXEC  = 2'd0;
  localparam logic [1:0] OPC_HWR   = 2'd1;
  localparam logic [1:0] OPC_HRD   = 2'd2;

  localparam logic [7:0] IC_LOAD  = 8'd1;
  localparam logic [7:0] IC_STOR  = 8'd2;
  localparam logic [7:0] IC_SET   = 8'd3;
  localparam logic [7:0] IC_RST   = 8'd4;
  localparam logic [7:0] IC_AND   = 8'd5;
  localparam logic [7:0] IC_OR    = 8'd6;
  localparam logic [7:0] IC_XOR   = 8'd7;
  localparam logic [7:0] IC_ADD   = 8'd8;
  localparam logic [7:0] IC_SUB   = 8'd9;
  localparam logic [7:0] IC_MUL   = 8'd10;
  localparam logic [7:0] IC_DIV   = 8'd11;
  localparam logic [7:0] IC_GT    = 8'd12;
  localparam logic [7:0] IC_GE    = 8'd13;
  localparam logic [7:0] IC_EQ    = 8'd14;
  localparam logic [7:0] IC_NE    = 8'd15;
  localparam logic [7:0] IC_LE    = 8'd16;
  localparam logic [7:0] IC_LT    = 8'd17;
  localparam logic [7:0] IC_JUMP  = 8'd18;
  localparam logic [7:0] IC_CALL  = 8'd19;
  localparam logic [7:0] IC_RET   = 8'd20;
  localparam logic [7:0] IC_CLOSE = 8'd21;

  localparam logic [15:0] END_LINE = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,  // clearing pass over the data memory
    ST_IDLE,   // waiting for a request
    ST_READ,   // memory read in flight
    ST_EXEC,   // apply operation, write back
    ST_DIV,    // iterative divide
    ST_OUT     // result waiting to be taken
  } state_t;
endpackage
`default_nettype wire

// ===== design/plc_instruction_list_executor_top.sv =====
// Top level: PLC instruction-list executor with data memory and stacks
`default_nettype none
// One request at a time. A request passes through accept, memory read and
// execute to its result. A DIV with a nonzero divisor then runs the
// one-bit-a-cycle divider (16 steps, then a step to load the quotient).
// After reset a clearing pass writes zero to the data memory, one word a
// cycle, over all MEM_WORDS words, during which no request is taken. The
// data memory, the deferred stack and the call stack are synchronous
// memories with registered reads; each request reads them once and writes
// back at most once.
`include "assert_macros.svh"
module plc_instruction_list_executor_top #(
  parameter int MEM_WORDS  = 1024,
  parameter int EVAL_DEPTH = 16,
  parameter int CALL_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // opcode[1:0], instruction_code[9:2], flag_immediate[10], flag_negate[11],
  // flag_conditional[12], flag_open_paren[13], operand[29:14],
  // current_line[45:30], host_data[61:46], zero[63:62]
  input  wire logic [63:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // next_line[15:0], accumulator[31:16], read_data[47:32],
  // divide_by_zero[48], zero[55:49]
  output logic [55:0]      m_tdata
);
  import plcile_pkg::*;

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int EW = $clog2(EVAL_DEPTH);
  localparam int CW = $clog2(CALL_DEPTH);
  localparam int ECW = $clog2(EVAL_DEPTH + 1);
  localparam int CCW = $clog2(CALL_DEPTH + 1);

  state_t state, state_next;

  // request fields
  logic [1:0]  opc;
  logic [7:0]  code;
  logic        imm, neg, cnd, par;
  logic [15:0] opd, line, hdata;

  // architectural registers
  logic [15:0]  accum;
  logic [ECW-1:0] dcount;
  logic [CCW-1:0] rcount;

  // memories
  logic [15:0] dmem [MEM_WORDS];
  logic [25:0] dstk [EVAL_DEPTH];  // code[7:0], neg, accumulator
  logic [15:0] rstk [CALL_DEPTH];
  logic [15:0] dmem_q, rstk_q;
  logic [25:0] dstk_q;

  logic [AW:0] clr_addr;

  // result registers
  logic [15:0] r_next, r_acc, r_rd;
  logic        r_dz;

  // divider
  logic [15:0] div_q, div_r, div_d;
  logic [4:0]  div_n;
  logic [16:0] div_trial;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {7'd0, r_dz, r_rd, r_acc, r_next};

  // next state
  logic is_div;
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == (AW+1)'(MEM_WORDS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (s_tvalid) state_next = ST_READ;
      ST_READ:  state_next = ST_EXEC;
      ST_EXEC:  state_next = is_div ? ST_DIV : ST_OUT;
      ST_DIV:   if (div_n == 5'd16) state_next = ST_OUT;
      ST_OUT:   if (m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  // capture request
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      opc   <= s_tdata[1:0];
      code  <= s_tdata[9:2];
      imm   <= s_tdata[10];
      neg   <= s_tdata[11];
      cnd   <= s_tdata[12];
      par   <= s_tdata[13];
      opd   <= s_tdata[29:14];
      line  <= s_tdata[45:30];
      hdata <= s_tdata[61:46];
    end
  end

  // decode (valid in ST_READ and ST_EXEC)
  logic is_bin, is_close, close_ok, push;
  logic [15:0] rd_addr;
  logic        in_rng;
  assign is_bin   = (code >= IC_AND) && (code <= IC_LT);
  assign is_close = (opc == OPC_EXEC) && (code == IC_CLOSE);
  assign close_ok = (dcount != '0) && (dcount < ECW'(EVAL_DEPTH));
  assign push     = (opc == OPC_EXEC) && par &&
                    (code == IC_LOAD || code == IC_STOR || is_bin);

  // memory read address: closing deferred LOAD reads at accumulator
  assign rd_addr = is_close ? accum : opd;
  assign in_rng  = ({16'd0, rd_addr} < 32'(MEM_WORDS));

  logic [EW-1:0] dtop;
  logic [CW-1:0] rtop;
  assign dtop = EW'(dcount - 1'b1);
  assign rtop = CW'(rcount - 1'b1);

  // synchronous reads on every clock; the address is set in ST_READ, the data used in ST_EXEC
  always_ff @(posedge clk) begin
    dmem_q <= dmem[rd_addr[AW-1:0]];
    dstk_q <= dstk[dtop];
    rstk_q <= rstk[rtop];
  end

  // operand construction for execute
  logic [15:0] mword, mval;
  logic        active, taken;
  logic [7:0]  ecode;
  logic        eneg;
  logic [15:0] a_op, b_raw, b_op, alu;
  logic [31:0] prod;
  logic [15:0] nxt;
  logic        wr_en;
  logic [15:0] wr_addr, wr_data;
  logic [15:0] acc_new;

  assign mword  = in_rng ? dmem_q : 16'd0;
  assign active = neg ? (accum == 16'd0) : (accum != 16'd0);
  assign taken  = !cnd || active;

  // operation applied: either direct or popped from deferred stack
  always_comb begin
    if (is_close) begin
      ecode = dstk_q[25:18];
      eneg  = dstk_q[17];
      a_op  = dstk_q[15:0];
      b_raw = accum;
    end else begin
      ecode = code;
      eneg  = neg;
      a_op  = accum;
      b_raw = imm ? opd : mword;
    end
    b_op = eneg ? ~b_raw : b_raw;
    prod = {16'd0, a_op} * {16'd0, b_op};
    alu = 16'd0;
    case (ecode)
      IC_LOAD: alu = eneg ? ~mword : mword;
      IC_STOR: alu = a_op;
      IC_AND:  alu = a_op & b_op;
      IC_OR:   alu = a_op | b_op;
      IC_XOR:  alu = a_op ^ b_op;
      IC_ADD:  alu = a_op + b_op;
      IC_SUB:  alu = a_op - b_op;
      IC_MUL:  alu = prod[15:0];
      IC_GT:   alu = {15'd0, a_op > b_op};
      IC_GE:   alu = {15'd0, a_op >= b_op};
      IC_EQ:   alu = {15'd0, a_op == b_op};
      IC_NE:   alu = {15'd0, a_op != b_op};
      IC_LE:   alu = {15'd0, a_op <= b_op};
      IC_LT:   alu = {15'd0, a_op < b_op};
      default: alu = 16'd0;
    endcase
    is_div = (opc == OPC_EXEC) && !push && (ecode == IC_DIV) && b_op != 16'd0 &&
             ((is_close && close_ok) || (!is_close && code == IC_DIV));
  end

  // per-request effects
  always_comb begin
    nxt     = line + 16'd1;
    wr_en   = 1'b0;
    wr_addr = opd;
    wr_data = 16'd0;
    acc_new = accum;
    case (opc)
      OPC_HWR: begin
        wr_en = 1'b1;
        wr_data = hdata;
      end
      OPC_EXEC: begin
        case (code)
          IC_SET, IC_RST: begin
            wr_en = active;
            wr_data = (code == IC_SET) ? 16'd1 : 16'd0;
          end
          IC_JUMP: if (taken) nxt = opd;
          IC_CALL: if (taken && rcount < CCW'(CALL_DEPTH)) nxt = opd;
          IC_RET: begin
            if (taken) nxt = (rcount != '0) ? rstk_q : END_LINE;
          end
          IC_LOAD, IC_STOR: begin
            if (par) acc_new = opd;
            else if (code == IC_STOR) begin
              wr_en = 1'b1;
              wr_data = neg ? ~accum : accum;
            end else acc_new = imm ? opd : (neg ? ~mword : mword);
          end
          IC_CLOSE: begin
            if (close_ok) begin
              if (ecode == IC_STOR) begin
                wr_en = 1'b1;
                wr_addr = accum;
                wr_data = eneg ? ~a_op : a_op;
              end
              acc_new = alu;
              if (ecode == IC_DIV && b_op == 16'd0) acc_new = 16'hFFFF;
            end
          end
          default: begin
            if (is_bin) begin
              if (par) acc_new = b_raw;
              else begin
                acc_new = alu;
                if (code == IC_DIV && b_op == 16'd0) acc_new = 16'hFFFF;
              end
            end
          end
        endcase
      end
      default: ;
    endcase
    if (!({16'd0, wr_addr} < 32'(MEM_WORDS))) wr_en = 1'b0;
  end

  // data memory write port: clearing pass or execute write-back
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR)
      dmem[clr_addr[AW-1:0]] <= 16'd0;
    else if (state == ST_EXEC && wr_en)
      dmem[wr_addr[AW-1:0]] <= wr_data;
  end

  // stack memories
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && push && dcount < ECW'(EVAL_DEPTH))
      dstk[dcount[EW-1:0]] <= {code, neg, 1'b0, accum};
    if (state == ST_EXEC && opc == OPC_EXEC && code == IC_CALL && taken &&
        rcount < CCW'(CALL_DEPTH))
      rstk[rcount[CW-1:0]] <= line + 16'd1;
  end

  // architectural registers and results
  always_ff @(posedge clk) begin
    if (rst) begin
      accum  <= 16'd0;
      dcount <= '0;
      rcount <= '0;
    end else if (state == ST_EXEC) begin
      accum <= acc_new;
      if (push && dcount < ECW'(EVAL_DEPTH)) dcount <= dcount + 1'b1;
      if (is_close && close_ok) dcount <= dcount - 1'b1;
      if (opc == OPC_EXEC && code == IC_CALL && taken &&
          rcount < CCW'(CALL_DEPTH))
        rcount <= rcount + 1'b1;
      if (opc == OPC_EXEC && code == IC_RET && taken && rcount != '0)
        rcount <= rcount - 1'b1;
    end else if (state == ST_DIV && div_n == 5'd16) begin
      accum <= div_q;
    end
  end

  // result register and restoring divider
  assign div_trial = {div_r, div_q[15]} - {1'b0, div_d};
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      r_next <= (opc == OPC_EXEC) ? nxt : 16'd0;
      r_acc  <= acc_new;
      r_rd   <= (opc == OPC_HRD) ? mword : 16'd0;
      r_dz   <= (opc == OPC_EXEC) && !push && (ecode == IC_DIV) && (b_op == 16'd0) &&
                ((is_close && close_ok) || (!is_close && code == IC_DIV));
      div_q  <= a_op;
      div_r  <= 16'd0;
      div_d  <= b_op;
      div_n  <= 5'd0;
    end else if (state == ST_DIV) begin
      if (div_n == 5'd16) r_acc <= div_q;
      else begin
        div_n <= div_n + 5'd1;
        if (!div_trial[16]) begin
          div_r <= div_trial[15:0];
          div_q <= {div_q[14:0], 1'b1};
        end else begin
          div_r <= {div_r[14:0], div_q[15]};
          div_q <= {div_q[14:0], 1'b0};
        end
      end
    end
  end

  `ASSERT_IMPL(a_one_side, clk, rst, 1'b1, !(s_tready && m_tvalid),
               "input and output sides open together")
  `ASSERT_NEXT(a_hold_out, clk, rst, m_tvalid && !m_tready, m_tvalid,
               "result dropped before taken")
  `ASSERT_IMPL(a_dcount_rng, clk, rst, 1'b1, dcount <= ECW'(EVAL_DEPTH),
               "deferred count beyond depth")
  `ASSERT_IMPL(a_rcount_rng, clk, rst, 1'b1, rcount <= CCW'(CALL_DEPTH),
               "call count beyond depth")
endmodule
`default_nettype wire

// ===== bench/tb_plc_instruction_list_executor_top.sv =====
// Testbench for the PLC instruction-list executor: random and directed requests with a scoreboard
`timescale 1ns / 100ps
`default_nettype none
module tb_plc_instruction_list_executor_top;
  import plcile_pkg::*;

  localparam int MEM_WORDS  = 1024;
  localparam int EVAL_DEPTH = 16;
  localparam int CALL_DEPTH = 16;
  localparam int AW = $clog2(MEM_WORDS);
  localparam int EW = $clog2(EVAL_DEPTH);
  localparam int CW = $clog2(CALL_DEPTH);
  localparam logic [7:0] IC_NOP = 8'd0;
  localparam logic [1:0] OPC_NONE = 2'd3;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] host_data;
    logic [15:0] current_line;
    logic [15:0] operand;
    logic        open_paren;
    logic        cond;
    logic        negate;
    logic        immediate;
    logic [7:0]  code;
    logic [1:0]  opcode;
  } request_t;

  typedef struct packed {
    logic        div_zero;
    logic [15:0] read_data;
    logic [15:0] accumulator;
    logic [15:0] next_line;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;

  plc_instruction_list_executor_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Shadow state of the executor
  logic [15:0] shadow_mem [MEM_WORDS];
  logic [15:0] shadow_acc;
  logic [31:0] shadow_defer [EVAL_DEPTH];
  int          shadow_defer_cnt;
  logic [15:0] shadow_ret [CALL_DEPTH];
  int          shadow_ret_cnt;
  logic        shadow_divz;

  outcome_t pending_outcomes[$];
  int  error_count = 0;
  bit  finished = 0;
  longint cycle_count = 0;

  initial forever #6 clk = ~clk;

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] rand_code(int lo, int hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  function automatic logic [15:0] mem_fetch(logic [15:0] addr, logic neg);
    logic [15:0] w;
    w = (addr < MEM_WORDS) ? shadow_mem[addr[AW-1:0]] : 16'd0;
    return neg ? ~w : w;
  endfunction

  function automatic void mem_put(logic [15:0] addr, logic [15:0] v, logic neg);
    if (addr < MEM_WORDS) shadow_mem[addr[AW-1:0]] = neg ? ~v : v;
  endfunction

  function automatic void defer_push(logic [7:0] code, logic neg, logic [15:0] acc);
    if (shadow_defer_cnt < EVAL_DEPTH) begin
      shadow_defer[shadow_defer_cnt[EW-1:0]] = {2'b00, neg, 5'b0, code, acc};
      shadow_defer_cnt++;
    end
  endfunction

  function automatic logic [15:0] combine(logic [7:0] code, logic neg,
                                          logic [15:0] a, logic [15:0] b);
    logic [15:0] y;
    y = neg ? ~b : b;
    case (code)
      IC_LOAD: return mem_fetch(b, neg);
      IC_STOR: begin mem_put(b, a, neg); return a; end
      IC_AND:  return a & y;
      IC_OR:   return a | y;
      IC_XOR:  return a ^ y;
      IC_ADD:  return a + y;
      IC_SUB:  return a - y;
      IC_MUL:  return a * y;
      IC_DIV: begin
        if (y == 16'd0) begin shadow_divz = 1'b1; return 16'hFFFF; end
        return a / y;
      end
      IC_GT: return {15'd0, a > y};
      IC_GE: return {15'd0, a >= y};
      IC_EQ: return {15'd0, a == y};
      IC_NE: return {15'd0, a != y};
      IC_LE: return {15'd0, a <= y};
      IC_LT: return {15'd0, a < y};
      default: return 16'd0;
    endcase
  endfunction

  // Works out the result of one request and advances the shadow state
  function automatic outcome_t predict_step(request_t r);
    outcome_t o;
    logic [15:0] nxt, val;
    logic active;
    logic [31:0] e;
    o = '0;
    shadow_divz = 1'b0;
    if (r.opcode == OPC_EXEC) begin
      nxt = r.current_line + 16'd1;
      active = r.negate ? (shadow_acc == 16'd0) : (shadow_acc != 16'd0);
      case (r.code)
        IC_SET, IC_RST:
          if (active) mem_put(r.operand, (r.code == IC_SET) ? 16'd1 : 16'd0, 1'b0);
        IC_JUMP, IC_CALL, IC_RET:
          if (!(r.cond && !active)) begin
            if (r.code == IC_JUMP) nxt = r.operand;
            else if (r.code == IC_CALL) begin
              if (shadow_ret_cnt < CALL_DEPTH) begin
                shadow_ret[shadow_ret_cnt[CW-1:0]] = nxt;
                shadow_ret_cnt++;
                nxt = r.operand;
              end
            end else if (shadow_ret_cnt > 0) begin
              shadow_ret_cnt--;
              nxt = shadow_ret[shadow_ret_cnt[CW-1:0]];
            end else nxt = END_LINE;
          end
        IC_LOAD, IC_STOR:
          if (r.open_paren) begin
            defer_push(r.code, r.negate, shadow_acc);
            shadow_acc = r.operand;
          end else if (r.code == IC_STOR) mem_put(r.operand, shadow_acc, r.negate);
          else shadow_acc = r.immediate ? r.operand : mem_fetch(r.operand, r.negate);
        IC_CLOSE:
          if (shadow_defer_cnt > 0 && shadow_defer_cnt < EVAL_DEPTH) begin
            shadow_defer_cnt--;
            e = shadow_defer[shadow_defer_cnt[EW-1:0]];
            shadow_acc = combine(e[23:16], e[29], e[15:0], shadow_acc);
          end
        default:
          if (r.code >= IC_AND && r.code <= IC_LT) begin
            val = r.immediate ? r.operand : mem_fetch(r.operand, 1'b0);
            if (r.open_paren) begin
              defer_push(r.code, r.negate, shadow_acc);
              shadow_acc = val;
            end else shadow_acc = combine(r.code, r.negate, shadow_acc, val);
          end
      endcase
      o.next_line = nxt;
    end else if (r.opcode == OPC_HWR) mem_put(r.operand, r.host_data, 1'b0);
    else if (r.opcode == OPC_HRD) o.read_data = mem_fetch(r.operand, 1'b0);
    o.accumulator = shadow_acc;
    o.div_zero = shadow_divz;
    return o;
  endfunction

  // Sends one request after a random gap; prediction made at acceptance.
  // Valid stays up after acceptance until the next call drops it or
  // presents the next request, so each falling edge sees one drive.
  task automatic send_request(request_t r);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {2'b00, r};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_outcomes.push_back(predict_step(r));
    @(negedge clk);
  endtask

  function automatic request_t make_exec(logic [7:0] code, logic [15:0] opd,
                                         logic imm = 1'b0, logic neg = 1'b0,
                                         logic cnd = 1'b0, logic par = 1'b0);
    request_t r;
    r = '0;
    r.opcode = OPC_EXEC; r.code = code; r.operand = opd;
    r.immediate = imm; r.negate = neg; r.cond = cnd; r.open_paren = par;
    r.current_line = rand16();
    r.host_data = rand16();
    return r;
  endfunction

  function automatic request_t make_host(logic [1:0] opc, logic [15:0] addr,
                                         logic [15:0] data);
    request_t r;
    r = '0;
    r.opcode = opc; r.operand = addr; r.host_data = data;
    r.code = rand_code(0, 255);
    r.current_line = rand16();
    return r;
  endfunction

  function automatic logic [15:0] small_addr();
    return 16'($urandom_range(0, 15));
  endfunction

  // Receiver side: random stalls and the result check
  initial begin
    outcome_t got, want;
    int stall;
    @(negedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = m_tdata[48:0];
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (got.next_line !== want.next_line) begin
          $display("%0t: next_line exp %h got %h", $time, want.next_line, got.next_line);
          error_count++;
        end
        if (got.accumulator !== want.accumulator) begin
          $display("%0t: accumulator exp %h got %h", $time, want.accumulator,
                   got.accumulator);
          error_count++;
        end
        if (got.read_data !== want.read_data) begin
          $display("%0t: read_data exp %h got %h", $time, want.read_data, got.read_data);
          error_count++;
        end
        if (got.div_zero !== want.div_zero) begin
          $display("%0t: divide_by_zero exp %b got %b", $time, want.div_zero,
                   got.div_zero);
          error_count++;
        end
        if (m_tdata[55:49] !== '0) begin
          $display("%0t: pad bits exp 0 got %h", $time, m_tdata[55:49]);
          error_count++;
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT && !finished) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Host access, extremes of address and data
  task automatic test_host_access();
    send_request(make_host(OPC_HRD, 16'd5, 16'd0));
    send_request(make_host(OPC_HWR, 16'd0, 16'hFFFF));
    send_request(make_host(OPC_HWR, 16'(MEM_WORDS - 1), 16'hA5A5));
    send_request(make_host(OPC_HWR, 16'hFFFF, 16'h1234));
    send_request(make_host(OPC_HRD, 16'(MEM_WORDS - 1), 16'd0));
    send_request(make_host(OPC_HRD, 16'hFFFF, 16'd0));
    send_request(make_host(OPC_NONE, 16'd0, 16'd0));
  endtask

  // Load, store, logic, arithmetic, compare, SET, RST, JUMP and RET, including division by zero and unknown codes
  task automatic test_operations();
    send_request(make_exec(IC_LOAD, 16'd0));
    send_request(make_exec(IC_LOAD, 16'd0, 1'b0, 1'b1));
    send_request(make_exec(IC_STOR, 16'd3, 1'b0, 1'b1));
    for (int c = IC_AND; c <= IC_LT; c++)
      send_request(make_exec(c[7:0], rand16(), 1'b1, coin()));
    send_request(make_exec(IC_LOAD, 16'd7, 1'b1));
    send_request(make_exec(IC_DIV, 16'd0, 1'b1));
    send_request(make_exec(IC_SET, 16'd4));
    send_request(make_exec(IC_RST, 16'd4, 1'b0, 1'b1));
    send_request(make_exec(IC_NOP, 16'd1));
    send_request(make_exec(8'd255, 16'd1));
    send_request(make_exec(IC_JUMP, 16'hFFFF));
    send_request(make_exec(IC_RET, 16'd0));
  endtask

  // Call stack to full and back past empty
  task automatic test_call_stack();
    for (int i = 0; i <= CALL_DEPTH; i++)
      send_request(make_exec(IC_CALL, rand16()));
    for (int i = 0; i <= CALL_DEPTH; i++)
      send_request(make_exec(IC_RET, 16'd0, 1'b0, coin(), coin()));
  endtask

  // Well-formed programs with deferred groups, mixed with host accesses and noise
  task automatic test_random_programs(int n);
    request_t r;
    int sent, k;
    logic [7:0] c;
    sent = 0;
    while (sent < n) begin
      k = $urandom_range(0, 9);
      if (k < 3) begin
        // a bracketed expression: op( ... ) one level deep, no nesting
        c = rand_code(IC_LOAD, IC_LT);
        if (c == IC_SET || c == IC_RST) c = IC_ADD;
        send_request(make_exec(c, (c <= IC_STOR) ? small_addr() : rand16(),
                               coin(), coin(), 1'b0, 1'b1));
        send_request(make_exec(rand_code(IC_AND, IC_LT), rand16(), 1'b1, coin()));
        if (c <= IC_STOR) send_request(make_exec(IC_LOAD, small_addr(), 1'b1));
        send_request(make_exec(IC_CLOSE, rand16()));
        sent += (c <= IC_STOR) ? 4 : 3;
      end else if (k < 5) begin
        r = make_host(2'($urandom_range(OPC_HWR, OPC_HRD)),
                      ($urandom_range(0, 7) == 0) ? rand16() : small_addr(),
                      rand16());
        send_request(r);
        sent++;
      end else if (k < 8) begin
        c = rand_code(IC_LOAD, IC_LT);
        send_request(make_exec(c, coin() ? small_addr() : rand16(),
                               coin(), coin(), coin(), 1'b0));
        sent++;
      end else begin
        // branches and noise: random code and flags, deferring kept rare
        r = make_exec((k == 8) ? rand_code(IC_JUMP, IC_CLOSE) : rand_code(0, 255),
                      rand16(), coin(), coin(), coin(),
                      ($urandom_range(0, 15) == 0));
        send_request(r);
        sent++;
      end
    end
  endtask

  // Deferred stack driven into its stuck state last, as it lasts until reset
  task automatic test_defer_overflow();
    for (int i = 0; i <= EVAL_DEPTH; i++)
      send_request(make_exec(IC_ADD, rand16(), 1'b1, 1'b0, 1'b0, 1'b1));
    send_request(make_exec(IC_CLOSE, 16'd0));
    send_request(make_exec(IC_CLOSE, 16'd0));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < MEM_WORDS; i++) shadow_mem[i] = '0;
    shadow_acc = '0;
    shadow_defer_cnt = 0;
    shadow_ret_cnt = 0;
    test_host_access();
    test_operations();
    test_call_stack();
    test_random_programs(316);
    test_defer_overflow();
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    finished = 1;
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+design
design/plcile_pkg.sv
design/plc_instruction_list_executor_top.sv
bench/tb_plc_instruction_list_executor_top.sv
